### rtl/core/rgbdct_pkg.sv
// ============================================================================
// rgbdct_pkg: shared types and constants for the 2x2 RGB to Y/Pb/Pr block
// Datapath commands and status between controller and datapath.
// ============================================================================
package rgbdct_pkg;

    // controller to datapath commands
    typedef struct packed {
        logic       start_div;   // load divider with a new sample
        logic [1:0] div_sel;     // which sample: 0 red, 1 green, 2 blue
        logic       store_frac;  // capture divider quotient
        logic       mult_step;   // run one matrix step
        logic [1:0] mult_sel;    // 0 Y, 1 Pb, 2 Pr
        logic       accum;       // fold pixel into block state
        logic       finish;      // compute block results
    } rgbdct_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } rgbdct_sts_t;

    localparam logic [1:0] SEL_R = 2'd0;
    localparam logic [1:0] SEL_G = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;

    // matrix rows; the last code is the drain step of the row sequence
    localparam logic [1:0] ROW_Y   = 2'd0;
    localparam logic [1:0] ROW_PB  = 2'd1;
    localparam logic [1:0] ROW_PR  = 2'd2;
    localparam logic [1:0] ROW_END = 2'd3;

endpackage

### rtl/core/rgbdct_ctrl.sv
// ============================================================================
// rgbdct_ctrl: sequencer for one pixel
// Divider over 3 samples, 3 rows and a drain, fold; 4th pixel: finish, output.
// ============================================================================
module rgbdct_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   last_pixel,
    input  logic                   out_free,
    input  rgbdct_pkg::rgbdct_sts_t sts,
    output rgbdct_pkg::rgbdct_cmd_t cmd,
    output logic                   busy,
    output logic                   result_load
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = rgbdct_pkg::SEL_R;
                    idx_next      = 2'd0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.store_frac = 1'b1;
                    cmd.div_sel    = idx_reg;
                    if (idx_reg == rgbdct_pkg::SEL_B) begin
                        idx_next   = 2'd0;
                        state_next = ST_MUL;
                    end else begin
                        idx_next      = idx_reg + 2'd1;
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_MUL: begin
                cmd.mult_step = 1'b1;
                cmd.mult_sel  = idx_reg;
                if (idx_reg == rgbdct_pkg::ROW_END) begin
                    state_next = ST_ACC;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = last_pixel ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

### rtl/core/rgbdct_dpath.sv
// ============================================================================
// rgbdct_dpath: divider, matrix and block accumulator
// Restoring divider one quotient bit per cycle, one multiply row per cycle.
// ============================================================================
module rgbdct_dpath #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rgbdct_pkg::rgbdct_cmd_t cmd,
    output rgbdct_pkg::rgbdct_sts_t sts,
    input  logic [15:0]            max_value,
    input  logic [15:0]            red,
    input  logic [15:0]            green,
    input  logic [15:0]            blue,
    output logic [1:0]             pos,
    output logic [16:0]            coef_a,
    output logic [16:0]            coef_b,
    output logic [16:0]            coef_c,
    output logic [16:0]            coef_d,
    output logic [16:0]            mean_pb,
    output logic [16:0]            mean_pr
);
    localparam int FW  = FRACTION_BITS + 2;          // fraction incl. sign
    localparam int NW  = 16 + FRACTION_BITS + 1;     // dividend width
    localparam int CW  = $clog2(NW + 1);
    localparam int PW  = FW + 22;                    // product width
    localparam int SW  = FW + 4;                     // block sum width
    localparam int QW  = FRACTION_BITS + 15;         // biased numerator width
    localparam int MW  = FRACTION_BITS + 16;         // reciprocal width
    localparam logic signed [PW-1:0] HALF_M  = PW'(500000);
    // ceil(2^(QW+14) / 15625), exact floor division for numerators below 2^QW
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) <<< (QW + 14)) + longint'(15624)) / longint'(15625));
    localparam logic signed [PW-1:0] ROFF = PW'(longint'(15625) <<< (FRACTION_BITS - 1));
    localparam logic signed [PW-1:0] QOFF = PW'(longint'(1) <<< (FRACTION_BITS - 1));

    // ---- divider: round(s*2^F/m) = floor((2*s*2^F + m) / (2m)) ----
    logic [NW-1:0] quo_reg, quo_next;
    logic [17:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [16:0]   div2m;
    logic [15:0]   m, s_raw, s_clamp;
    logic [NW-1:0] dividend;
    logic [18:0]   trial;

    assign m       = (max_value == 16'd0) ? 16'd1 : max_value;
    assign div2m   = {m, 1'b0};
    logic [1:0] sel;
    assign sel = cmd.store_frac ? cmd.div_sel + 2'd1 : cmd.div_sel;
    always_comb begin
        case (sel)
            rgbdct_pkg::SEL_R: s_raw = red;
            rgbdct_pkg::SEL_G: s_raw = green;
            default:           s_raw = blue;
        endcase
    end
    logic [15:0] s_mask;
    assign s_mask   = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    assign s_clamp  = ((s_raw & s_mask) > m) ? m : (s_raw & s_mask);
    assign dividend = (NW'(s_clamp) << (FRACTION_BITS + 1)) + NW'(m);
    assign trial    = {rem_reg, quo_reg[NW-1]} - {2'b0, div2m};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (cmd.start_div) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!trial[18]) begin
                rem_next = trial[17:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[16:0], quo_reg[NW-1]};
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) run_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
    assign sts.div_done = !run_reg && (cnt_reg == '0);

    // ---- fractions ----
    logic signed [FW-1:0] fr_reg, fg_reg, fb_reg;
    always_ff @(posedge aclk) begin
        if (cmd.store_frac) begin
            case (cmd.div_sel)
                rgbdct_pkg::SEL_R: fr_reg <= FW'(quo_reg);
                rgbdct_pkg::SEL_G: fg_reg <= FW'(quo_reg);
                default:           fb_reg <= FW'(quo_reg);
            endcase
        end
    end

    // ---- matrix: one row per step, a product per step into a rounding stage ----
    logic signed [PW-1:0] kr, kg, kb, dot;
    always_comb begin
        case (cmd.mult_sel)
            rgbdct_pkg::ROW_Y: begin
                kr = PW'(299000);  kg = PW'(587000);  kb = PW'(114000);
            end
            rgbdct_pkg::ROW_PB: begin
                kr = -PW'(168736); kg = -PW'(331264); kb = PW'(500000);
            end
            default: begin
                kr = PW'(500000);  kg = -PW'(418688); kb = -PW'(81312);
            end
        endcase
    end
    assign dot = kr * PW'(fr_reg) + kg * PW'(fg_reg) + kb * PW'(fb_reg);

    logic signed [PW-1:0] dot_reg;
    logic [1:0]           dsel_reg;
    logic                 dval_reg;
    logic signed [PW-1:0] rnum, rsh, rq;
    logic [QW-1:0]        ru;
    logic [QW+MW-1:0]     rprod;
    assign rnum  = dot_reg + HALF_M;
    // floor(rnum / 10^6) = floor(floor(rnum / 64) / 15625): shift, bias to a
    // non-negative value, multiply by the reciprocal of 15625, remove the bias
    assign rsh   = rnum >>> 6;
    assign ru    = QW'(rsh + ROFF);
    assign rprod = ru * RECIP;
    assign rq    = PW'(rprod >> (QW + 14)) - QOFF;

    logic signed [FW-1:0] y_reg, pb_reg, pr_reg;
    always_ff @(posedge aclk) begin
        dot_reg  <= dot;
        dsel_reg <= cmd.mult_sel;
        if (!aresetn) dval_reg <= 1'b0;
        else          dval_reg <= cmd.mult_step && (cmd.mult_sel != rgbdct_pkg::ROW_END);
        if (dval_reg) begin
            case (dsel_reg)
                rgbdct_pkg::ROW_Y:  y_reg  <= FW'(rq);
                rgbdct_pkg::ROW_PB: pb_reg <= FW'(rq);
                default:            pr_reg <= FW'(rq);
            endcase
        end
    end

    // ---- block state ----
    logic signed [FW-1:0] luma_reg [4];
    logic signed [SW-1:0] sum_pb_reg, sum_pr_reg;
    logic [1:0]           pos_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 2'd0;
            sum_pb_reg <= '0;
            sum_pr_reg <= '0;
        end else if (cmd.accum) begin
            luma_reg[pos_reg] <= y_reg;
            pos_reg           <= pos_reg + 2'd1;
            sum_pb_reg        <= sum_pb_reg + SW'(pb_reg);
            sum_pr_reg        <= sum_pr_reg + SW'(pr_reg);
        end else if (cmd.finish) begin
            sum_pb_reg <= '0;
            sum_pr_reg <= '0;
        end
    end
    assign pos = pos_reg;

    // ---- results: round(x/4) ties up = (x+2)>>>2 ----
    logic signed [SW-1:0] y0, y1, y2, y3, ta, tb, tc, td;
    assign y0 = SW'(luma_reg[0]);
    assign y1 = SW'(luma_reg[1]);
    assign y2 = SW'(luma_reg[2]);
    assign y3 = SW'(luma_reg[3]);
    assign ta = (y0 + y1 + y2 + y3 + SW'(2)) >>> 2;
    assign tb = (y2 + y3 - y0 - y1 + SW'(2)) >>> 2;
    assign tc = (y1 + y3 - y0 - y2 + SW'(2)) >>> 2;
    assign td = (y0 + y3 - y1 - y2 + SW'(2)) >>> 2;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            coef_a  <= ta[16:0];
            coef_b  <= tb[16:0];
            coef_c  <= tc[16:0];
            coef_d  <= td[16:0];
            mean_pb <= 17'((sum_pb_reg + SW'(2)) >>> 2);
            mean_pr <= 17'((sum_pr_reg + SW'(2)) >>> 2);
        end
    end
endmodule

### rtl/core/block_rgb_to_dct_chroma_avg_unit.sv
// ============================================================================
// block_rgb_to_dct_chroma_avg_unit: 2x2 RGB block to luma transform and chroma
// Top level: controller, datapath, output register.
// ============================================================================
// Takes one pixel per transfer, the four pixels of a 2x2 block in row-major
// order, and after the fourth gives coefficients a..d of the lumas and the
// Pb/Pr means. The one-bit-per-cycle divider scales the three samples by
// max_value in turn; no new pixel is taken until the last is through, and
// the fourth adds a finish and an output step. Results wait in an output
// register while the next pixel is taken.
module block_rgb_to_dct_chroma_avg_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // red[15:0], green[31:16], blue[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // coef_a, coef_b, coef_c, coef_d, mean_pb,
                                    // mean_pr, 17 bits each from bit 0; pad
);
    rgbdct_pkg::rgbdct_cmd_t cmd;
    rgbdct_pkg::rgbdct_sts_t sts;
    logic [15:0]  max_value_reg;
    logic [47:0]  pix_reg;
    logic [47:0]  pix_src;
    logic         busy, result_load, start;
    logic [1:0]   pos;
    logic [16:0]  ca, cb, cc, cd, mpb, mpr;
    logic         mvalid_reg;
    logic [101:0] mdata_reg;

    // hold the configured maximum
    always_ff @(posedge aclk) begin
        if (!aresetn)   max_value_reg <= 16'd255;
        else if (cfg_we) max_value_reg <= cfg_wdata;
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    // capture the pixel on transfer
    always_ff @(posedge aclk) begin
        if (start) pix_reg <= s_tdata;
    end

    // the divider loads red in the transfer cycle, before the capture lands
    assign pix_src = start ? s_tdata : pix_reg;

    rgbdct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .last_pixel(pos == 2'd3),
        .out_free(!mvalid_reg || m_tready), .sts(sts), .cmd(cmd),
        .busy(busy), .result_load(result_load)
    );

    rgbdct_dpath #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .max_value(max_value_reg), .red(pix_src[15:0]), .green(pix_src[31:16]),
        .blue(pix_src[47:32]), .pos(pos), .coef_a(ca), .coef_b(cb), .coef_c(cc),
        .coef_d(cd), .mean_pb(mpb), .mean_pr(mpr)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (result_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (result_load) mdata_reg <= {mpr, mpb, cd, cc, cb, ca};
    end
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, mdata_reg};

    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |-> (!mvalid_reg || m_tready)) else $error("output overrun");
    // no pixel accepted while sequencer busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("accept while busy");
    // a new pixel makes the sequencer busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy) else $error("sequencer did not start");
endmodule

### dv/block_rgb_to_dct_chroma_avg_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// block_rgb_to_dct_chroma_avg_unit_tb: self-checking bench for the 2x2 block
// Streams 2x2 RGB blocks under several max_value settings with bursty input
// and a stalling receiver, predicts coefficients and chroma means per block,
// and compares every result transfer field by field.
// ============================================================================
module block_rgb_to_dct_chroma_avg_unit_tb;

    localparam int FB = 16;
    localparam longint BIAS = 64'd67108864;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } pixel_t;

    typedef struct packed {
        logic [16:0] mean_pr;
        logic [16:0] mean_pb;
        logic [16:0] coef_d;
        logic [16:0] coef_c;
        logic [16:0] coef_b;
        logic [16:0] coef_a;
    } block_res_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;   // red, green, blue, 16 bits each from bit 0
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // coef_a, coef_b, coef_c, coef_d, mean_pb, mean_pr; pad

    pixel_t     pixel_q[$];
    block_res_t block_exp_q[$];
    int         n_errors;
    int         n_pushed;
    int         n_accepted;
    int         n_results;

    // predictor state
    logic [15:0] cur_max;
    int          pix_pos;
    longint      luma_hold[4];
    longint      pb_sum;
    longint      pr_sum;

    // sender pacing
    int burst_left;
    int gap_left;

    // receiver pacing
    int rx_cyc;
    int rx_period;
    int rx_duty;
    int hold_cnt;
    bit hold_done;

    block_rgb_to_dct_chroma_avg_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // round to nearest, ties up
    function automatic longint round_div(longint x, longint d);
        return (x + d * BIAS + d / 2) / d - BIAS;
    endfunction

    function automatic longint sample_frac(logic [15:0] s, logic [15:0] mv);
        longint m;
        longint v;
        m = (mv == 16'd0) ? 1 : longint'(mv);
        v = longint'(s);
        if (v > m) v = m;
        return ((v << FB) + m / 2) / m;
    endfunction

    // fold one accepted pixel into the block state; queue a result on the fourth
    task automatic predict_pixel(pixel_t px);
        longint fr, fg, fb, y, pb, pr;
        block_res_t r;
        fr = sample_frac(px.red, cur_max);
        fg = sample_frac(px.green, cur_max);
        fb = sample_frac(px.blue, cur_max);
        y  = round_div(299000 * fr + 587000 * fg + 114000 * fb, 1000000);
        pb = round_div(-168736 * fr - 331264 * fg + 500000 * fb, 1000000);
        pr = round_div(500000 * fr - 418688 * fg - 81312 * fb, 1000000);
        luma_hold[pix_pos] = y;
        pb_sum += pb;
        pr_sum += pr;
        if (pix_pos != 3) begin
            pix_pos++;
        end else begin
            r.coef_a  = 17'(round_div(luma_hold[0] + luma_hold[1] + luma_hold[2]
                                      + luma_hold[3], 4));
            r.coef_b  = 17'(round_div(luma_hold[2] + luma_hold[3] - luma_hold[0]
                                      - luma_hold[1], 4));
            r.coef_c  = 17'(round_div(luma_hold[1] + luma_hold[3] - luma_hold[0]
                                      - luma_hold[2], 4));
            r.coef_d  = 17'(round_div(luma_hold[0] + luma_hold[3] - luma_hold[1]
                                      - luma_hold[2], 4));
            r.mean_pb = 17'(round_div(pb_sum, 4));
            r.mean_pr = 17'(round_div(pr_sum, 4));
            block_exp_q.push_back(r);
            pix_pos = 0;
            pb_sum  = 0;
            pr_sum  = 0;
        end
    endtask

    // driver: bursts of transfers with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(pixel_t'(s_tdata));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(150);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: duty pattern that changes whenever its cycle counter wraps, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cyc    <= 0;
            rx_period <= 1;
            rx_duty   <= 1;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            if (!hold_done && n_accepted >= 600) begin
                hold_cnt  <= 4000;
                hold_done <= 1'b1;
            end
            if (rx_cyc >= 700) begin
                rx_cyc    <= 0;
                rx_period <= $urandom_range(300, 1);
                rx_duty   <= ($urandom_range(3) == 0) ? 1000 : $urandom_range(300);
            end else begin
                rx_cyc <= rx_cyc + 1;
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (rx_cyc % rx_period) < rx_duty;
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        block_res_t got;
        block_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = block_res_t'(m_tdata[101:0]);
            n_results++;
            if (block_exp_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_errors++;
            end else begin
                want = block_exp_q.pop_front();
                if (got.coef_a !== want.coef_a) begin
                    $error("coef_a exp %h got %h", want.coef_a, got.coef_a);
                    n_errors++;
                end
                if (got.coef_b !== want.coef_b) begin
                    $error("coef_b exp %h got %h", want.coef_b, got.coef_b);
                    n_errors++;
                end
                if (got.coef_c !== want.coef_c) begin
                    $error("coef_c exp %h got %h", want.coef_c, got.coef_c);
                    n_errors++;
                end
                if (got.coef_d !== want.coef_d) begin
                    $error("coef_d exp %h got %h", want.coef_d, got.coef_d);
                    n_errors++;
                end
                if (got.mean_pb !== want.mean_pb) begin
                    $error("mean_pb exp %h got %h", want.mean_pb, got.mean_pb);
                    n_errors++;
                end
                if (got.mean_pr !== want.mean_pr) begin
                    $error("mean_pr exp %h got %h", want.mean_pr, got.mean_pr);
                    n_errors++;
                end
            end
        end
    end

    task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixel_q.push_back(px);
        n_pushed++;
    endtask

    // hold until all transfers are done and the block has drained
    task automatic wait_drained();
        while (n_accepted != n_pushed || block_exp_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_max(logic [15:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_max = v;
    endtask

    function automatic logic [15:0] rand_sample(int mode, logic [15:0] mv);
        case (mode)
            0: return 16'($urandom_range(mv));
            1: return 16'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 16'd0;
                    1: return mv;
                    2: return 16'hFFFF;
                    default: return (mv == 16'hFFFF) ? mv : mv + 16'd1;
                endcase
            end
        endcase
    endfunction

    task automatic random_blocks(int n_blocks);
        int mode;
        for (int k = 0; k < n_blocks; k++) begin
            mode = $urandom_range(9);
            mode = (mode < 7) ? 0 : (mode < 8) ? 1 : 2;
            for (int p = 0; p < 4; p++)
                push_pixel(rand_sample(mode, cur_max), rand_sample(mode, cur_max),
                           rand_sample(mode, cur_max));
        end
    endtask

    // stimulus
    initial begin
        logic [15:0] max_list[5];
        n_errors   = 0;
        n_pushed   = 0;
        n_accepted = 0;
        n_results  = 0;
        cur_max    = 16'd255;
        pix_pos    = 0;
        pb_sum     = 0;
        pr_sum     = 0;
        foreach (luma_hold[i]) luma_hold[i] = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed blocks at the reset max_value
        repeat (4) push_pixel(16'd0, 16'd0, 16'd0);
        repeat (4) push_pixel(16'd255, 16'd255, 16'd255);
        repeat (4) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);   // clamp above max
        push_pixel(16'd0, 16'd0, 16'd0);      // dark top, bright bottom
        push_pixel(16'd0, 16'd0, 16'd0);
        push_pixel(16'd255, 16'd255, 16'd255);
        push_pixel(16'd255, 16'd255, 16'd255);
        push_pixel(16'd255, 16'd255, 16'd255);   // bright diagonal
        push_pixel(16'd0, 16'd0, 16'd0);
        push_pixel(16'd0, 16'd0, 16'd0);
        push_pixel(16'd255, 16'd255, 16'd255);
        push_pixel(16'd0, 16'd0, 16'd255);   // chroma extremes: blue and red
        push_pixel(16'd0, 16'd0, 16'd255);
        push_pixel(16'd255, 16'd0, 16'd0);
        push_pixel(16'd255, 16'd0, 16'd0);
        wait_drained();

        max_list[0] = 16'd1;
        max_list[1] = 16'hFFFF;
        max_list[2] = 16'd1023;
        max_list[3] = 16'($urandom_range(65535, 2));
        max_list[4] = 16'd255;
        foreach (max_list[i]) begin
            write_max(max_list[i]);
            if (max_list[i] == 16'hFFFF) begin
                repeat (4) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
                push_pixel(16'hFFFF, 16'd0, 16'd0);
                push_pixel(16'd0, 16'hFFFF, 16'd0);
                push_pixel(16'd0, 16'd0, 16'hFFFF);
                push_pixel(16'h5555, 16'hAAAA, 16'h5555);
            end
            random_blocks(66);
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### block_rgb_to_dct_chroma_avg_unit.f
rtl/core/rgbdct_pkg.sv
rtl/core/rgbdct_ctrl.sv
rtl/core/rgbdct_dpath.sv
rtl/core/block_rgb_to_dct_chroma_avg_unit.sv
dv/block_rgb_to_dct_chroma_avg_unit_tb.sv
